// ===== sv/dhfk_pkg.sv =====
package dhfk_pkg;

    // cordic configuration
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    // fixed point constants
    localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [63:0] HALF_Q30    = 64'sd536870912;

    // control travelling alongside the operands of the multiply-accumulate unit
    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic [3:0] tag;
    } mac_ctl_t;

    // arctangent table, degrees * 100 * 65536
    function automatic logic signed [32:0] atan_val(input logic [STEP_W-1:0] i);
        logic signed [32:0] v;
        case (i)
            5'd0:    v = 33'sd294912000;
            5'd1:    v = 33'sd174096719;
            5'd2:    v = 33'sd91987925;
            5'd3:    v = 33'sd46694507;
            5'd4:    v = 33'sd23437865;
            5'd5:    v = 33'sd11730358;
            5'd6:    v = 33'sd5866610;
            5'd7:    v = 33'sd2933484;
            5'd8:    v = 33'sd1466765;
            5'd9:    v = 33'sd733385;
            5'd10:   v = 33'sd366693;
            5'd11:   v = 33'sd183346;
            5'd12:   v = 33'sd91673;
            5'd13:   v = 33'sd45837;
            5'd14:   v = 33'sd22919;
            5'd15:   v = 33'sd11459;
            5'd16:   v = 33'sd5730;
            5'd17:   v = 33'sd2865;
            5'd18:   v = 33'sd1432;
            5'd19:   v = 33'sd716;
            5'd20:   v = 33'sd358;
            5'd21:   v = 33'sd179;
            5'd22:   v = 33'sd90;
            5'd23:   v = 33'sd45;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

    // round a q60 sum back to q30: add half, floor shift
    function automatic logic signed [33:0] rnd30(input logic signed [63:0] v);
        logic signed [63:0] s;
        s = v + HALF_Q30;
        return s[63:30];
    endfunction

    // clamp to [-1.0, 1.0] in q30
    function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd1073741824)
            r = ONE_Q30;
        else if (v < -34'sd1073741824)
            r = -ONE_Q30;
        else
            r = v[31:0];
        return r;
    endfunction

    // saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -35'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== sv/dh_forward_kinematics_chain.sv =====
// each joint takes two 24-step cordic runs, theta then alpha, and 6 products
// on one shared mac; a chained joint adds 36 frame products, a chain start none
// no new item is taken until the last row leaves
// an ignored joint gives one flagged row on the next cycle
// reset: frame is identity with zero position, joint count zero
module dh_forward_kinematics_chain
    import dhfk_pkg::*;
#(
    parameter int MAX_JOINTS = 6
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // joint_angle, twist_angle, link_length, joint_offset, zero pad
    input  logic [95:0]  s_tdata,
    // chain_start
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // joint_number, row_index, rot_col0, rot_col1, rot_col2, position, zero pad
    output logic [135:0] m_tdata,
    // chain_overflow
    output logic         m_tuser,
    output logic         m_tlast
);

    typedef enum logic [3:0] {
        S_IDLE, S_TH, S_AL, S_TR, S_TRW, S_FR, S_FRW, S_COMMIT, S_OUT, S_OVF
    } state_t;

    // products of the joint transform
    localparam logic [3:0] JOB_ST_CA = 4'd0;
    localparam logic [3:0] JOB_CT_CA = 4'd1;
    localparam logic [3:0] JOB_ST_SA = 4'd2;
    localparam logic [3:0] JOB_CT_SA = 4'd3;
    localparam logic [3:0] JOB_SA_D  = 4'd4;
    localparam logic [3:0] JOB_CA_D  = 4'd5;
    localparam logic [3:0] TAG_FR_LAST = {2'd2, 2'd3};

    state_t             state_reg;
    logic [3:0]         count_reg;
    logic               start_reg;
    logic signed [15:0] alpha_reg;
    logic signed [31:0] d_reg;
    logic signed [31:0] a_reg;
    logic signed [31:0] st_reg;
    logic signed [31:0] ct_reg;
    logic signed [31:0] sa_reg;
    logic signed [31:0] ca_reg;
    logic [3:0]         job_reg;
    logic [1:0]         row_reg;
    logic [1:0]         col_reg;
    logic [1:0]         k_reg;
    logic [1:0]         out_row_reg;
    logic signed [31:0] rot_reg [9];
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] tr_reg  [9];
    logic signed [31:0] tp_reg  [3];
    logic signed [31:0] nr_reg  [9];
    logic signed [31:0] np_reg  [3];

    logic               s_accept;
    logic               ovf_in;
    logic               cdc_start;
    logic signed [15:0] cdc_angle;
    logic               cdc_done;
    logic signed [31:0] cdc_sin;
    logic signed [31:0] cdc_cos;
    mac_ctl_t           mac_ctl;
    mac_ctl_t           mac_res;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [63:0] mac_acc;
    logic signed [33:0] res_rnd;
    logic signed [34:0] pos_sum;
    logic [3:0]         fr_ridx;
    logic [3:0]         fr_tidx;
    logic [3:0]         wr_idx;
    logic [1:0]         wr_row;
    logic [3:0]         out_idx;
    logic               fr_phase;

    // input handshake
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign ovf_in   = !s_tuser && (count_reg >= 4'(MAX_JOINTS));

    // shared sine-cosine unit, theta first then alpha
    assign cdc_start = (s_accept && !ovf_in) || (state_reg == S_TH && cdc_done);
    assign cdc_angle = (state_reg == S_IDLE) ? signed'(s_tdata[15:0]) : alpha_reg;

    dhfk_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cdc_start),
        .angle   (cdc_angle),
        .done    (cdc_done),
        .sin_val (cdc_sin),
        .cos_val (cdc_cos)
    );

    // operand selection for the multiply-accumulate unit
    assign fr_ridx = 4'({2'b00, row_reg} * 4'd3 + {2'b00, k_reg});
    assign fr_tidx = 4'({2'b00, k_reg} * 4'd3 + {2'b00, col_reg});

    always_comb
    begin
        mac_ctl = '0;
        op_a    = '0;
        op_b    = '0;
        if (state_reg == S_TR)
        begin
            mac_ctl.valid = 1'b1;
            mac_ctl.first = 1'b1;
            mac_ctl.last  = 1'b1;
            mac_ctl.tag   = job_reg;
            case (job_reg)
                JOB_ST_CA: begin op_a = st_reg;  op_b = ca_reg; end
                JOB_CT_CA: begin op_a = ct_reg;  op_b = ca_reg; end
                JOB_ST_SA: begin op_a = st_reg;  op_b = sa_reg; end
                JOB_CT_SA: begin op_a = ct_reg;  op_b = sa_reg; end
                JOB_SA_D:  begin op_a = -sa_reg; op_b = d_reg;  end
                JOB_CA_D:  begin op_a = ca_reg;  op_b = d_reg;  end
                default:   begin op_a = '0;      op_b = '0;     end
            endcase
        end
        else if (state_reg == S_FR)
        begin
            mac_ctl.valid = 1'b1;
            mac_ctl.first = (k_reg == 2'd0);
            mac_ctl.last  = (k_reg == 2'd2);
            mac_ctl.tag   = {row_reg, col_reg};
            op_a          = rot_reg[fr_ridx];
            op_b          = (col_reg == 2'd3) ? tp_reg[k_reg] : tr_reg[fr_tidx];
        end
    end

    dhfk_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .op_a    (op_a),
        .op_b    (op_b),
        .res_ctl (mac_res),
        .acc     (mac_acc)
    );

    // rounding and write-back index of a finished sum
    assign fr_phase = (state_reg == S_FR) || (state_reg == S_FRW);
    assign res_rnd  = rnd30(mac_acc);
    assign wr_row   = mac_res.tag[3:2];
    assign wr_idx   = 4'({2'b00, wr_row} * 4'd3 + {2'b00, mac_res.tag[1:0]});
    assign pos_sum  = 35'(res_rnd) + 35'(pos_reg[wr_row]);

    // sequencer, frame state and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            start_reg   <= 1'b0;
            job_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            k_reg       <= '0;
            out_row_reg <= '0;
            for (int i = 0; i < 9; i++)
                rot_reg[i] <= (i % 4 == 0) ? ONE_Q30 : 32'sd0;
            for (int i = 0; i < 3; i++)
                pos_reg[i] <= '0;
        end
        else
        begin
            // finished sums land in the transform or the new frame
            if (mac_res.valid)
            begin
                if (!fr_phase)
                begin
                    case (mac_res.tag)
                        JOB_ST_CA: tr_reg[3] <= clamp_q30(res_rnd);
                        JOB_CT_CA: tr_reg[4] <= clamp_q30(res_rnd);
                        JOB_ST_SA: tr_reg[6] <= clamp_q30(res_rnd);
                        JOB_CT_SA: tr_reg[7] <= clamp_q30(res_rnd);
                        JOB_SA_D:  tp_reg[1] <= res_rnd[31:0];
                        JOB_CA_D:  tp_reg[2] <= res_rnd[31:0];
                        default:   ;
                    endcase
                end
                else if (mac_res.tag[1:0] == 2'd3)
                    np_reg[wr_row] <= sat32(pos_sum);
                else
                    nr_reg[wr_idx] <= clamp_q30(res_rnd);
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_accept)
                    begin
                        alpha_reg <= signed'(s_tdata[31:16]);
                        a_reg     <= 32'(signed'(s_tdata[62:32]));
                        d_reg     <= 32'(signed'(s_tdata[93:63]));
                        start_reg <= s_tuser;
                        state_reg <= ovf_in ? S_OVF : S_TH;
                    end
                end
                S_TH:
                begin
                    if (cdc_done)
                    begin
                        st_reg    <= cdc_sin;
                        ct_reg    <= cdc_cos;
                        state_reg <= S_AL;
                    end
                end
                S_AL:
                begin
                    if (cdc_done)
                    begin
                        sa_reg    <= cdc_sin;
                        ca_reg    <= cdc_cos;
                        tr_reg[0] <= ct_reg;
                        tr_reg[1] <= -st_reg;
                        tr_reg[2] <= '0;
                        tr_reg[5] <= -cdc_sin;
                        tr_reg[8] <= cdc_cos;
                        tp_reg[0] <= a_reg;
                        job_reg   <= JOB_ST_CA;
                        state_reg <= S_TR;
                    end
                end
                S_TR:
                begin
                    job_reg <= job_reg + 1'b1;
                    if (job_reg == JOB_CA_D)
                        state_reg <= S_TRW;
                end
                S_TRW:
                begin
                    if (mac_res.valid && mac_res.tag == JOB_CA_D)
                    begin
                        row_reg   <= '0;
                        col_reg   <= '0;
                        k_reg     <= '0;
                        state_reg <= start_reg ? S_COMMIT : S_FR;
                    end
                end
                S_FR:
                begin
                    if (k_reg == 2'd2)
                    begin
                        k_reg <= '0;
                        if (col_reg == 2'd3)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + 1'b1;
                            if (row_reg == 2'd2)
                                state_reg <= S_FRW;
                        end
                        else
                            col_reg <= col_reg + 1'b1;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                S_FRW:
                begin
                    if (mac_res.valid && mac_res.tag == TAG_FR_LAST)
                        state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    for (int i = 0; i < 9; i++)
                        rot_reg[i] <= start_reg ? tr_reg[i] : nr_reg[i];
                    for (int i = 0; i < 3; i++)
                        pos_reg[i] <= start_reg ? tp_reg[i] : np_reg[i];
                    count_reg   <= start_reg ? 4'd1 : count_reg + 4'd1;
                    out_row_reg <= '0;
                    state_reg   <= S_OUT;
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        out_row_reg <= out_row_reg + 1'b1;
                        if (out_row_reg == 2'd2)
                            state_reg <= S_IDLE;
                    end
                end
                S_OVF:
                begin
                    if (m_tready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // output rows straight from the frame registers
    assign out_idx  = 4'({2'b00, out_row_reg} * 4'd3);
    assign m_tvalid = (state_reg == S_OUT) || (state_reg == S_OVF);
    assign m_tuser  = (state_reg == S_OVF);
    assign m_tlast  = (state_reg == S_OUT) && (out_row_reg == 2'd2);

    always_comb
    begin
        m_tdata        = '0;
        m_tdata[3:0]   = count_reg;
        if (state_reg != S_OVF)
        begin
            m_tdata[5:4]     = out_row_reg;
            m_tdata[37:6]    = rot_reg[out_idx];
            m_tdata[69:38]   = rot_reg[out_idx + 4'd1];
            m_tdata[101:70]  = rot_reg[out_idx + 4'd2];
            m_tdata[133:102] = pos_reg[out_row_reg];
        end
    end

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 4'(MAX_JOINTS))
        else $error("joint count beyond maximum");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input taken while a row is pending");

    a_mac_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mac_res.valid |-> (state_reg == S_TR || state_reg == S_TRW ||
                           state_reg == S_FR || state_reg == S_FRW))
        else $error("sum finished outside a product phase");

    a_ovf_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser && m_tready) |=> s_tready)
        else $error("overflow item not followed by idle");
`endif

endmodule

// ===== sv/dhfk_cordic.sv =====
module dhfk_cordic
    import dhfk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] angle,
    output logic               done,
    output logic signed [31:0] sin_val,
    output logic signed [31:0] cos_val
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [STEP_W-1:0]       cnt_reg;
    logic                    neg_reg;
    logic signed [33:0]      x_reg;
    logic signed [33:0]      y_reg;
    logic signed [32:0]      z_reg;
    logic signed [31:0]      sin_reg;
    logic signed [31:0]      cos_reg;

    logic signed [16:0]      ang_w;
    logic signed [16:0]      ang_f;
    logic                    neg_f;
    logic signed [32:0]      z_init;
    logic signed [33:0]      xs;
    logic signed [33:0]      ys;
    logic signed [33:0]      x_next;
    logic signed [33:0]      y_next;
    logic signed [32:0]      z_next;

    // wrap into half a turn, then fold into the right half plane
    always_comb
    begin
        ang_w = 17'(angle);
        if (ang_w > 17'sd18000)
            ang_w = ang_w - 17'sd36000;
        else if (ang_w < -17'sd18000)
            ang_w = ang_w + 17'sd36000;
        neg_f = 1'b0;
        ang_f = ang_w;
        if (ang_w > 17'sd9000)
        begin
            ang_f = ang_w - 17'sd18000;
            neg_f = 1'b1;
        end
        else if (ang_w < -17'sd9000)
        begin
            ang_f = ang_w + 17'sd18000;
            neg_f = 1'b1;
        end
        z_init = 33'(ang_f) <<< 16;
    end

    // one rotation step per cycle
    always_comb
    begin
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        if (!z_reg[32])
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_val(cnt_reg);
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_val(cnt_reg);
        end
    end

    // iteration sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg && start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (!busy_reg && start)
        begin
            x_reg   <= CORDIC_GAIN;
            y_reg   <= '0;
            z_reg   <= z_init;
            neg_reg <= neg_f;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                cos_reg <= clamp_q30(neg_reg ? -x_next : x_next);
                sin_reg <= clamp_q30(neg_reg ? -y_next : y_next);
            end
        end
    end

    assign done    = done_reg;
    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// ===== sv/dhfk_mac.sv =====
module dhfk_mac
    import dhfk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mac_ctl_t           ctl,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output mac_ctl_t           res_ctl,
    output logic signed [63:0] acc
);

    mac_ctl_t           ctl1_reg;
    mac_ctl_t           res_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;

    // control pipeline, result flagged on the last term of a sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            res_reg  <= '0;
        end
        else
        begin
            ctl1_reg      <= ctl;
            res_reg.valid <= ctl1_reg.valid && ctl1_reg.last;
            res_reg.first <= ctl1_reg.first;
            res_reg.last  <= ctl1_reg.last;
            res_reg.tag   <= ctl1_reg.tag;
        end
    end

    // multiply stage then accumulate stage
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        if (ctl1_reg.valid)
        begin
            if (ctl1_reg.first)
                acc_reg <= prod_reg;
            else
                acc_reg <= acc_reg + prod_reg;
        end
    end

    assign res_ctl = res_reg;
    assign acc     = acc_reg;

endmodule

// ===== sim/dhfk_checker.sv =====
`timescale 1ns / 100ps

module dhfk_checker
    import dhfk_pkg::*;
#(
    parameter int MAX_JOINTS = 6
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [95:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    input  logic         m_tuser,
    input  logic         m_tlast,
    output int           fail_count,
    output int           rows_pending
);

    localparam longint UNIT_Q30 = 64'sd1073741824;
    localparam longint GAIN_Q30 = 64'sd652032874;

    typedef struct {
        logic [3:0]  joint_number;
        logic [1:0]  row_index;
        logic [31:0] rot_col0;
        logic [31:0] rot_col1;
        logic [31:0] rot_col2;
        logic [31:0] position;
        logic        last_row;
        logic        chain_overflow;
    } frame_row_t;

    const longint arctan_lut [24] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466765, 733385, 366693, 183346,
        91673, 45837, 22919, 11459, 5730, 2865,
        1432, 716, 358, 179, 90, 45
    };

    frame_row_t  expected_rows [$];
    longint      cum_rot [9];
    longint      cum_pos [3];
    int unsigned links_seen;

    function automatic longint limit(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint round_q30(longint p);
        return (p + 64'sd536870912) >>> 30;
    endfunction

    // fixed cordic sine and cosine of an angle in hundredths of a degree
    task automatic cordic_sincos(input longint ang, output longint s, output longint c);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        bit     flip;
        x = GAIN_Q30;
        y = 0;
        flip = 0;
        if (ang > 18000) ang -= 36000;
        if (ang < -18000) ang += 36000;
        if (ang > 9000)
        begin
            ang -= 18000;
            flip = 1;
        end
        else if (ang < -9000)
        begin
            ang += 18000;
            flip = 1;
        end
        z = ang * 65536;
        for (int i = 0; i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= arctan_lut[i];
            end
            else
            begin
                x += ys;
                y -= xs;
                z += arctan_lut[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = limit(x, -UNIT_Q30, UNIT_Q30);
        s = limit(y, -UNIT_Q30, UNIT_Q30);
    endtask

    // compute the rows that one joint produces and queue them
    task automatic predict_joint(input logic [95:0] data, input logic start);
        longint th, al, a, d, st, ct, sa, ca, acc;
        longint tr [9];
        longint tp [3];
        longint nr [9];
        longint np [3];
        frame_row_t row;
        th = longint'($signed(data[15:0]));
        al = longint'($signed(data[31:16]));
        a  = longint'($signed(data[62:32]));
        d  = longint'($signed(data[93:63]));
        if (!start && links_seen >= MAX_JOINTS)
        begin
            row = '{links_seen[3:0], 2'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1};
            expected_rows.push_back(row);
            return;
        end
        cordic_sincos(th, st, ct);
        cordic_sincos(al, sa, ca);
        tr[0] = ct;
        tr[1] = -st;
        tr[2] = 0;
        tr[3] = limit(round_q30(st * ca), -UNIT_Q30, UNIT_Q30);
        tr[4] = limit(round_q30(ct * ca), -UNIT_Q30, UNIT_Q30);
        tr[5] = -sa;
        tr[6] = limit(round_q30(st * sa), -UNIT_Q30, UNIT_Q30);
        tr[7] = limit(round_q30(ct * sa), -UNIT_Q30, UNIT_Q30);
        tr[8] = ca;
        tp[0] = a;
        tp[1] = round_q30(-sa * d);
        tp[2] = round_q30(ca * d);
        if (start)
        begin
            nr = tr;
            np = tp;
            links_seen = 1;
        end
        else
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    acc = 0;
                    for (int k = 0; k < 3; k++)
                        acc += cum_rot[r*3+k] * tr[k*3+j];
                    nr[r*3+j] = limit(round_q30(acc), -UNIT_Q30, UNIT_Q30);
                end
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += cum_rot[r*3+k] * tp[k];
                np[r] = limit(round_q30(acc) + cum_pos[r], -64'sd2147483648,
                              64'sd2147483647);
            end
            links_seen++;
        end
        cum_rot = nr;
        cum_pos = np;
        for (int r = 0; r < 3; r++)
        begin
            row.joint_number   = links_seen[3:0];
            row.row_index      = r[1:0];
            row.rot_col0       = cum_rot[r*3][31:0];
            row.rot_col1       = cum_rot[r*3+1][31:0];
            row.rot_col2       = cum_rot[r*3+2][31:0];
            row.position       = cum_pos[r][31:0];
            row.last_row       = (r == 2);
            row.chain_overflow = 1'b0;
            expected_rows.push_back(row);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // reset state mirrors the block: identity frame, zero position
    initial
    begin
        fail_count = 0;
        links_seen = 0;
        for (int i = 0; i < 9; i++)
            cum_rot[i] = (i % 4 == 0) ? UNIT_Q30 : 0;
        for (int i = 0; i < 3; i++)
            cum_pos[i] = 0;
    end

    assign rows_pending = expected_rows.size();

    // watch both channels at each rising edge
    always @(posedge clk)
    begin
        frame_row_t want;
        if (rst_n && s_tvalid && s_tready)
            predict_joint(s_tdata, s_tuser);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_rows.size() == 0)
            begin
                $error("unexpected row item: %0h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_rows.pop_front();
                check_field("joint_number", want.joint_number, m_tdata[3:0]);
                check_field("row_index", want.row_index, m_tdata[5:4]);
                check_field("rot_col0", want.rot_col0, m_tdata[37:6]);
                check_field("rot_col1", want.rot_col1, m_tdata[69:38]);
                check_field("rot_col2", want.rot_col2, m_tdata[101:70]);
                check_field("position", want.position, m_tdata[133:102]);
                check_field("last_row", want.last_row, m_tlast);
                check_field("chain_overflow", want.chain_overflow, m_tuser);
            end
        end
    end

endmodule

// ===== sim/tb_dh_forward_kinematics_chain.sv =====
`timescale 1ns / 100ps

module tb_dh_forward_kinematics_chain;

    localparam int STALL_LIMIT = 5000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    int           fail_count;
    int           rows_pending;
    int           joints_sent;
    int           burst_left;
    int           idle_cycles;
    bit           rx_hold;

    dh_forward_kinematics_chain u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    dhfk_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .rows_pending (rows_pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver stalls on its own pattern, with one long hold-off
    always @(posedge clk)
    begin
        int phase;
        phase = int'(($time / 256) % 3);
        if (rx_hold)
            m_tready <= 1'b0;
        else if (phase == 0)
            m_tready <= 1'b1;
        else if (phase == 1)
            m_tready <= 1'($urandom_range(0, 1));
        else
            m_tready <= ($urandom_range(0, 7) != 0);
    end

    initial
    begin
        rx_hold = 1'b0;
        wait (joints_sent >= 40);
        rx_hold = 1'b1;
        repeat (800) @(posedge clk);
        rx_hold = 1'b0;
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // offer one joint item and wait for it to be taken, then maybe gap
    task automatic send_joint(input logic signed [15:0] th, input logic signed [15:0] al,
                              input logic signed [30:0] a, input logic signed [30:0] d,
                              input logic start);
        s_tdata  <= {2'b00, d, a, al, th};
        s_tuser  <= start;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        joints_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 10);
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 150)) @(posedge clk);
            end
        end
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 2)) * 9000 - 9000);
            default: return 16'(int'($urandom_range(0, 36000)) - 18000);
        endcase
    endfunction

    function automatic logic [30:0] pick_length();
        case ($urandom_range(0, 7))
            0: return 31'($urandom);
            1: return 31'(1000000000);
            2: return 31'(-1000000000);
            3: return 31'($urandom_range(0, 2000));
            default: return 31'(longint'($urandom_range(0, 2000000000)) - 1000000000);
        endcase
    endfunction

    initial
    begin
        int chain_len;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        joints_sent = 0;
        burst_left = 1;
        idle_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no chain started: first joint multiplies onto the identity
        send_joint(16'sd3000, 16'sd0, 31'sd1000, 31'sd2000, 1'b0);
        // extremes of angles and lengths, including wrapped angles
        send_joint(16'sd18000, -16'sd18000, 31'sd1000000000, -31'sd1000000000, 1'b1);
        send_joint(-16'sd18000, 16'sd9000, -31'sd1073741824, 31'sd1073741823, 1'b0);
        send_joint(16'sd9000, -16'sd9000, 31'sd1073741823, -31'sd1073741824, 1'b0);
        send_joint(-16'sd9000, 16'sd9001, 31'sd0, 31'sd0, 1'b0);
        send_joint(16'sh7fff, 16'sh8000, 31'sd1000000000, 31'sd1000000000, 1'b0);
        send_joint(16'sh8000, 16'sh7fff, 31'sd1000000000, 31'sd1000000000, 1'b0);
        // too many joints: ignored and flagged
        send_joint(16'sd0, 16'sd0, 31'sd5, 31'sd5, 1'b0);
        send_joint(16'sd4500, 16'sd4500, 31'sd5, 31'sd5, 1'b0);
        // fresh chain pushing positions into saturation
        send_joint(16'sd0, 16'sd0, 31'sd1000000000, 31'sd1000000000, 1'b1);
        for (int i = 0; i < 5; i++)
            send_joint(16'sd0, 16'sd0, 31'sd1000000000, 31'sd1000000000, 1'b0);
        send_joint(16'sd0, 16'sd0, -31'sd1000000000, -31'sd1000000000, 1'b1);
        for (int i = 0; i < 5; i++)
            send_joint(16'sd0, 16'sd0, -31'sd1000000000, -31'sd1000000000, 1'b0);
        send_joint(-16'sd1, 16'sd1, -31'sd1, 31'sd1, 1'b0);

        // random chains with random content, some noise on the start mark
        while (joints_sent < 256)
        begin
            if (joints_sent > 150 && joints_sent < 160)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                wait (rows_pending == 0);
                @(posedge clk);
            end
            chain_len = $urandom_range(1, 8);
            for (int j = 0; j < chain_len; j++)
            begin
                if (j == 0)
                    send_joint(pick_angle(), pick_angle(), pick_length(), pick_length(),
                               ($urandom_range(0, 9) != 0));
                else
                    send_joint(pick_angle(), pick_angle(), pick_length(), pick_length(),
                               ($urandom_range(0, 19) == 0));
            end
        end
        s_tvalid <= 1'b0;

        // drain and settle
        @(posedge clk);
        wait (rows_pending == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && rows_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== dh_forward_kinematics_chain.f =====
sv/dhfk_pkg.sv
sv/dhfk_cordic.sv
sv/dhfk_mac.sv
sv/dh_forward_kinematics_chain.sv
sim/dhfk_checker.sv
sim/tb_dh_forward_kinematics_chain.sv
